[hw/rtl/csc_pkg.sv]
// ----------------------------------------------------------------------------
// csc_pkg
// shared types and constants of the circular stencil correlation block
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int MODE_W     = 2;
    localparam int POS_W      = 10;
    localparam int VAL_W      = 16;
    localparam int SCNT_W     = 11;
    localparam int TCNT_W     = 7;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int ACC_W      = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int MOD_STEP_W = $clog2(POS_W);

    localparam logic [SCNT_W-1:0] SAMPLE_COUNT_RST = 11'd1024;
    localparam logic [TCNT_W-1:0] TAP_COUNT_RST    = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT    = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_TAP     = 2'd0,
        MODE_SAMPLE  = 2'd1,
        MODE_COMPUTE = 2'd2
    } csc_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } csc_state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } csc_mac_ctrl_t;

endpackage

[hw/rtl/csc_ram.sv]
// ----------------------------------------------------------------------------
// csc_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module csc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/csc_mod.sv]
// ----------------------------------------------------------------------------
// csc_mod
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module csc_mod (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [csc_pkg::POS_W-1:0]  dividend,
    input  logic [csc_pkg::SCNT_W-1:0] divisor,
    output logic                      done,
    output logic [csc_pkg::SCNT_W-1:0] remainder
);

    import csc_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [MOD_STEP_W-1:0] step_reg;
    logic [MOD_STEP_W-1:0] step_next;
    logic [POS_W-1:0]      quo_reg;
    logic [POS_W-1:0]      quo_next;
    logic [SCNT_W-1:0]     rem_reg;
    logic [SCNT_W-1:0]     rem_next;
    logic [SCNT_W:0]       shifted;
    logic [SCNT_W:0]       reduced;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[POS_W-1]};
        reduced = (shifted >= {1'b0, divisor}) ? (shifted - {1'b0, divisor}) : shifted;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = MOD_STEP_W'(POS_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = reduced[SCNT_W-1:0];
            quo_next  = {quo_reg[POS_W-2:0], 1'b0};
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/csc_mac.sv]
// ----------------------------------------------------------------------------
// csc_mac
// registered multiply followed by a 40-bit accumulator
// ----------------------------------------------------------------------------
module csc_mac (
    input  logic                            clk,
    input  logic                            rst_n,
    input  csc_pkg::csc_mac_ctrl_t          ctrl,
    input  logic signed [csc_pkg::VAL_W-1:0] sample,
    input  logic signed [csc_pkg::VAL_W-1:0] tap,
    output logic signed [csc_pkg::ACC_W-1:0] acc,
    output logic                            done
);

    import csc_pkg::*;

    csc_mac_ctrl_t            prod_ctrl_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic                     done_reg;

    always_comb
    begin
        prod_next = sample * tap;
        prod_ext  = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        acc_next  = acc_reg;
        if (prod_ctrl_reg.valid)
        begin
            acc_next = prod_ctrl_reg.first ? prod_ext : (acc_reg + prod_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ctrl_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            prod_ctrl_reg <= ctrl;
            done_reg      <= prod_ctrl_reg.valid & prod_ctrl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

[hw/rtl/circular_stencil_correlation_top.sv]
// ----------------------------------------------------------------------------
// circular_stencil_correlation_top
// circular 1-d correlation engine over a sample ram and a tap ram
// ----------------------------------------------------------------------------
// s_axis carries one command per transfer: tuser selects tap load, sample
// load or compute; tdata holds position and value. loads write one ram entry.
// a compute request returns on m_axis the sum over p < tap_count of
// sample[(position + p) mod sample_count] * tap[p].
// cfg_we/cfg_index/cfg_data write sample_count (index 0) and tap_count
// (index 1); write them only while no compute is in flight.
// a compute holds s_axis off from acceptance until its result is moved into
// the output register, so no new command is accepted while it is in flight.
// the compute time is set by the ten-step remainder unit for the start index
// and by the single read port of each ram, one sample and one tap per cycle.
// the result sits in an output register: further loads and a new compute
// are accepted while it waits, and a finished compute holds until m_axis
// takes the earlier result. reset empties the output register and sets the
// counts to 1024 and 64; ram contents are undefined until written.
// ----------------------------------------------------------------------------
module circular_stencil_correlation_top #(
    parameter int SAMPLE_DEPTH = 1024,
    parameter int TAP_DEPTH    = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // position [9:0], value [25:10], zero pad [31:26]
    input  logic [31:0]                         s_axis_tdata,
    // mode [1:0]
    input  logic [csc_pkg::MODE_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_position [9:0], result_value [49:10], zero pad [55:50]
    output logic [55:0]                         m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [csc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csc_pkg::SCNT_W-1:0]          cfg_data
);

    import csc_pkg::*;

    localparam int SAW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int TAW = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;

    csc_state_t        state_reg;
    csc_state_t        state_next;
    logic [SCNT_W-1:0] sample_count_reg;
    logic [TCNT_W-1:0] tap_count_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [SCNT_W-1:0] idx_reg;
    logic [SCNT_W-1:0] idx_next;
    logic [TCNT_W-1:0] p_reg;
    logic [TCNT_W-1:0] p_next;
    csc_mac_ctrl_t     rd_ctrl_reg;
    csc_mac_ctrl_t     rd_ctrl_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [POS_W-1:0]  out_pos_reg;
    logic [ACC_W-1:0]  out_result_reg;

    logic [POS_W-1:0]  in_pos;
    logic [VAL_W-1:0]  in_val;
    logic              accept;
    logic              tap_we;
    logic              sample_we;
    logic              mod_start;
    logic              issue;
    logic              out_load;
    logic [SCNT_W-1:0] n_eff;
    logic [TCNT_W-1:0] k_eff;
    logic [TCNT_W-1:0] k_last;
    logic [SCNT_W:0]   idx_inc;
    logic              mod_done;
    logic [SCNT_W-1:0] mod_rem;
    logic [VAL_W-1:0]  sample_rdata;
    logic [VAL_W-1:0]  tap_rdata;
    logic [ACC_W-1:0]  mac_acc;
    logic              mac_done;

    assign in_pos = s_axis_tdata[POS_W-1:0];
    assign in_val = s_axis_tdata[POS_W+VAL_W-1:POS_W];

    // effective counts, out-of-range values clamp
    always_comb
    begin
        if (sample_count_reg == '0)
        begin
            n_eff = SCNT_W'(1);
        end
        else if (32'(sample_count_reg) > SAMPLE_DEPTH)
        begin
            n_eff = SCNT_W'(SAMPLE_DEPTH);
        end
        else
        begin
            n_eff = sample_count_reg;
        end
        if (tap_count_reg == '0)
        begin
            k_eff = TCNT_W'(1);
        end
        else if (32'(tap_count_reg) > TAP_DEPTH)
        begin
            k_eff = TCNT_W'(TAP_DEPTH);
        end
        else
        begin
            k_eff = tap_count_reg;
        end
        k_last = k_eff - 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_axis_tuser == MODE_COMPUTE))
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (p_reg == k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        accept        = s_axis_tvalid && s_axis_tready;
        tap_we        = accept && (s_axis_tuser == MODE_TAP) && (32'(in_pos) < TAP_DEPTH);
        sample_we     = accept && (s_axis_tuser == MODE_SAMPLE)
                        && (32'(in_pos) < SAMPLE_DEPTH);
        mod_start     = accept && (s_axis_tuser == MODE_COMPUTE);
        issue         = (state_reg == ST_RUN);
        out_load      = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);
    end

    // datapath next values
    always_comb
    begin
        pos_next           = pos_reg;
        idx_next           = idx_reg;
        p_next             = p_reg;
        idx_inc            = {1'b0, idx_reg} + 1'b1;
        rd_ctrl_next.valid = issue;
        rd_ctrl_next.first = (p_reg == '0);
        rd_ctrl_next.last  = (p_reg == k_last);
        if (mod_start)
        begin
            pos_next = in_pos;
        end
        if ((state_reg == ST_MOD) && mod_done)
        begin
            idx_next = mod_rem;
            p_next   = '0;
        end
        else if (issue)
        begin
            idx_next = (idx_inc >= {1'b0, n_eff}) ? '0 : idx_inc[SCNT_W-1:0];
            p_next   = p_reg + 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sample_count_reg <= SAMPLE_COUNT_RST;
            tap_count_reg    <= TAP_COUNT_RST;
            rd_ctrl_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_ctrl_reg <= rd_ctrl_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we && (cfg_index == REG_SAMPLE_COUNT))
            begin
                sample_count_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_TAP_COUNT))
            begin
                tap_count_reg <= cfg_data[TCNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        idx_reg <= idx_next;
        p_reg   <= p_next;
        if (out_load)
        begin
            out_pos_reg    <= pos_reg;
            out_result_reg <= mac_acc;
        end
    end

    csc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_sample_ram (
        .clk   (clk),
        .we    (sample_we),
        .waddr (SAW'(in_pos)),
        .wdata (in_val),
        .raddr (SAW'(idx_reg)),
        .rdata (sample_rdata)
    );

    csc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TAP_DEPTH)
    ) u_tap_ram (
        .clk   (clk),
        .we    (tap_we),
        .waddr (TAW'(in_pos)),
        .wdata (in_val),
        .raddr (TAW'(p_reg)),
        .rdata (tap_rdata)
    );

    csc_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (in_pos),
        .divisor   (n_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    csc_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (rd_ctrl_reg),
        .sample (sample_rdata),
        .tap    (tap_rdata),
        .acc    (mac_acc),
        .done   (mac_done)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0, out_result_reg, out_pos_reg};

    // accumulation can only finish while waiting on the pipeline
    a_mac_done_in_drain : assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == ST_DRAIN))
        else $error("accumulator finished outside drain");

    a_idx_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (idx_reg < n_eff))
        else $error("sample index beyond wrap length");

    a_tap_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (p_reg < k_eff))
        else $error("tap index beyond tap count");

    a_load_sets_valid : assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid)
        else $error("result lost on output load");

endmodule
